/* rtl/ramr_pkg.sv */
// Package for the rational add/multiply/reduce unit.
// Holds field widths, command codes, the sequencer state type and the
// status struct shared by the iterative units. No dependencies.
package ramr_pkg;

	localparam int FIELD_WIDTH_DEF = 16;
	localparam int CMD_W           = 2;
	localparam int RES_NUM_W       = 32;
	localparam int RES_DEN_W       = 30;

	localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MUL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CMP = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_DEN,
		S_GCD_GO,
		S_GCD_WAIT,
		S_DIVN_GO,
		S_DIVN_WAIT,
		S_DIVD_GO,
		S_DIVD_WAIT,
		S_WRITE
	} seq_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_stat_t;

endpackage

/* rtl/ramr_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on nothing but its parameter; the sequencer selects the operands.
module ramr_mul #(
	parameter int OPW = 17
) (
	input  logic                    clk,
	input  logic signed [OPW-1:0]   op_a,
	input  logic signed [OPW-1:0]   op_b,
	output logic signed [2*OPW-1:0] prod
);

	logic signed [2*OPW-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

/* rtl/ramr_gcd.sv */
// Iterative binary gcd, one shift or one subtract per cycle.
// Uses ramr_pkg for the status struct. Both operands must be nonzero.
module ramr_gcd #(
	parameter int WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [WIDTH-1:0]                x_in,
	input  logic [WIDTH-1:0]                y_in,
	output logic [WIDTH-1:0]                g,
	output ramr_pkg::iter_stat_t            stat
);
	import ramr_pkg::*;

	localparam int KW = $clog2(WIDTH);

	logic [WIDTH-1:0] x_q, y_q, g_q;
	logic [KW-1:0]    k_q;
	logic             busy_q, done_q;
	logic             x_gt;
	logic [WIDTH-1:0] big, sml, diff;

	assign x_gt = x_q > y_q;
	assign big  = x_gt ? x_q : y_q;
	assign sml  = x_gt ? y_q : x_q;
	assign diff = big - sml;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && x_q == y_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_in;
			y_q <= y_in;
			k_q <= '0;
		end else if (busy_q) begin
			priority if (x_q == y_q) begin
				g_q <= x_q << k_q;
			end else if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_gt) begin
				// both odd: replace the larger by the difference
				x_q <= diff;
			end else begin
				y_q <= diff;
			end
		end
	end

	assign g         = g_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* rtl/ramr_div.sv */
// Restoring divider, one quotient bit per cycle, WIDTH quotient bits per division.
// Uses ramr_pkg for the status struct. The divisor must be nonzero.
module ramr_div #(
	parameter int WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WIDTH-1:0]     dividend,
	input  logic [WIDTH-1:0]     divisor,
	output logic [WIDTH-1:0]     quotient,
	output ramr_pkg::iter_stat_t stat
);
	import ramr_pkg::*;

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] quo_q, rem_q, dsr_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [WIDTH:0]   trial, trial_sub;
	logic             fits;

	assign trial     = {rem_q, quo_q[WIDTH-1]};
	assign trial_sub = trial - {1'b0, dsr_q};
	assign fits      = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// shift in the next dividend bit, keep the remainder below the divisor
			rem_q <= fits ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* rtl/rational_add_mul_reduce_unit.sv */
// Rational add/multiply with reduction to lowest terms.
// Input channel in_valid/in_ready carries cmd, a_num, a_den, b_num, b_den;
// output channel out_valid/out_ready carries res_num, res_den, equal.
// cmd add gives a_num*b_den + b_num*a_den over a_den*b_den, cmd multiply the
// product of numerators over the product of denominators; both are divided
// by the gcd of the numerator magnitude and the denominator, and a zero
// numerator gives 0/1. Compare gives 0/1 with equal set when both fraction
// fields match; the unused command gives 0/1. A zero denominator on add or
// multiply gives 0/0.
// One transaction at a time: in_ready is high only while the sequencer is
// idle. With M = 2*FIELD_WIDTH, add and multiply form terms on the shared
// multiplier in steps MUL1, MUL2, MUL3 and DEN, then run binary gcd steps at
// one per cycle and two divisions of M quotient bits each on the shared
// divider, numerator first, then denominator. A zero numerator skips gcd and
// division; compare, the unused command and the zero-denominator case go
// from idle straight to the write step.
// The result sits in an output register; the sequencer holds in its write
// step while the receiver stalls and a previous result is still pending.
// Reset clears the sequencer and out_valid; no transaction is in flight after it.
module rational_add_mul_reduce_unit #(
	parameter int FIELD_WIDTH = ramr_pkg::FIELD_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [ramr_pkg::CMD_W-1:0]             cmd,
	input  logic signed [FIELD_WIDTH-1:0]          a_num,
	input  logic [FIELD_WIDTH-2:0]                 a_den,
	input  logic signed [FIELD_WIDTH-1:0]          b_num,
	input  logic [FIELD_WIDTH-2:0]                 b_den,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [ramr_pkg::RES_NUM_W-1:0]  res_num,
	output logic [ramr_pkg::RES_DEN_W-1:0]         res_den,
	output logic                                   equal
);
	import ramr_pkg::*;

	localparam int OPW = FIELD_WIDTH + 1;
	localparam int MW  = 2 * FIELD_WIDTH;

	seq_state_t state_q, state_d;

	logic [CMD_W-1:0]              cmd_q;
	logic signed [FIELD_WIDTH-1:0] an_q, bn_q;
	logic [FIELD_WIDTH-2:0]        ad_q, bd_q;
	logic signed [MW-1:0]          num_q;
	logic [MW-1:0]                 mag_q, den_q, g_q;
	logic                          neg_q, eq_q;

	logic signed [RES_NUM_W-1:0]   res_num_q;
	logic [RES_DEN_W-1:0]          res_den_q;
	logic                          equal_q, out_valid_q;

	logic signed [OPW-1:0]         op_a, op_b;
	logic signed [2*OPW-1:0]       prod;
	logic [MW-1:0]                 prod_t;

	logic                          gcd_start, div_start, div_den;
	logic [MW-1:0]                 gcd_g, div_q, div_dividend;
	iter_stat_t                    gcd_stat, div_stat;

	logic                          accept, out_free, dens_zero;
	logic signed [MW-1:0]          snum;

	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign dens_zero = (a_den == '0) || (b_den == '0);
	assign prod_t    = MW'(prod);

	ramr_mul #(.OPW(OPW)) u_mul (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	ramr_gcd #(.WIDTH(MW)) u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.x_in   (mag_q),
		.y_in   (den_q),
		.g      (gcd_g),
		.stat   (gcd_stat)
	);

	assign div_dividend = div_den ? den_q : mag_q;

	ramr_div #(.WIDTH(MW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (g_q),
		.quotient (div_q),
		.stat     (div_stat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd == CMD_CMP || cmd == CMD_NOP || dens_zero) begin
						state_d = S_WRITE;
					end else begin
						state_d = S_MUL1;
					end
				end
			end
			S_MUL1:      state_d = S_MUL2;
			S_MUL2:      state_d = S_MUL3;
			S_MUL3:      state_d = S_DEN;
			S_DEN:       state_d = (num_q == '0) ? S_WRITE : S_GCD_GO;
			S_GCD_GO:    state_d = S_GCD_WAIT;
			S_GCD_WAIT:  state_d = gcd_stat.done ? S_DIVN_GO : S_GCD_WAIT;
			S_DIVN_GO:   state_d = S_DIVN_WAIT;
			S_DIVN_WAIT: state_d = div_stat.done ? S_DIVD_GO : S_DIVN_WAIT;
			S_DIVD_GO:   state_d = S_DIVD_WAIT;
			S_DIVD_WAIT: state_d = div_stat.done ? S_WRITE : S_DIVD_WAIT;
			S_WRITE:     state_d = out_free ? S_IDLE : S_WRITE;
			default:     state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		gcd_start = 1'b0;
		div_start = 1'b0;
		div_den   = 1'b0;
		op_a      = OPW'(an_q);
		op_b      = OPW'(bn_q);
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_MUL1: begin
				op_a = OPW'(an_q);
				op_b = (cmd_q == CMD_ADD) ? OPW'(bd_q) : OPW'(bn_q);
			end
			S_MUL2: begin
				op_a = OPW'(bn_q);
				op_b = OPW'(ad_q);
			end
			S_MUL3: begin
				op_a = OPW'(ad_q);
				op_b = OPW'(bd_q);
			end
			S_GCD_GO: gcd_start = 1'b1;
			S_DIVN_GO: div_start = 1'b1;
			S_DIVD_GO: begin
				div_start = 1'b1;
				div_den   = 1'b1;
			end
			S_DIVD_WAIT: div_den = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_WRITE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign snum = neg_q ? -$signed(mag_q) : $signed(mag_q);

	// datapath; payload registers carry no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			an_q  <= a_num;
			ad_q  <= a_den;
			bn_q  <= b_num;
			bd_q  <= b_den;
			mag_q <= '0;
			neg_q <= 1'b0;
			den_q <= MW'(1);
			eq_q  <= 1'b0;
			if (cmd == CMD_CMP) begin
				eq_q <= (a_num == b_num) && (a_den == b_den);
			end else if (cmd != CMD_NOP && dens_zero) begin
				den_q <= '0;
			end
		end
		unique case (state_q)
			S_MUL2: num_q <= $signed(prod_t);
			S_MUL3: begin
				if (cmd_q == CMD_ADD) begin
					num_q <= num_q + $signed(prod_t);
				end
			end
			S_DEN: begin
				// zero numerator leaves magnitude 0 over 1
				if (num_q == '0) begin
					den_q <= MW'(1);
				end else begin
					den_q <= prod_t;
				end
				neg_q <= num_q < 0;
				mag_q <= (num_q < 0) ? MW'(-num_q) : MW'(num_q);
			end
			S_GCD_WAIT: begin
				if (gcd_stat.done) begin
					g_q <= gcd_g;
				end
			end
			S_DIVN_WAIT: begin
				if (div_stat.done) begin
					mag_q <= div_q;
				end
			end
			S_DIVD_WAIT: begin
				if (div_stat.done) begin
					den_q <= div_q;
				end
			end
			S_WRITE: begin
				if (out_free) begin
					res_num_q <= RES_NUM_W'(snum);
					res_den_q <= RES_DEN_W'(den_q);
					equal_q   <= eq_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign res_num   = res_num_q;
	assign res_den   = res_den_q;
	assign equal     = equal_q;

endmodule
